FILE: sv/tcp_ct_pkg.sv
`default_nettype none
package tcp_ct_pkg;

    // table size
    localparam int SLOTS  = 64;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    // configuration register indexes
    localparam logic [1:0] CFG_INIT_SEQ      = 2'd0;
    localparam logic [1:0] CFG_INIT_CWND     = 2'd1;
    localparam logic [1:0] CFG_INIT_SSTHRESH = 2'd2;

    // configuration reset values
    localparam logic [31:0] RST_INIT_SEQ      = 32'd1000;
    localparam logic [15:0] RST_INIT_CWND     = 16'd1;
    localparam logic [15:0] RST_INIT_SSTHRESH = 16'd64;

    // request actions
    localparam logic ACT_LISTEN  = 1'b0;
    localparam logic ACT_SEGMENT = 1'b1;

    // segment flag bit positions
    localparam int FLB_FIN = 0;
    localparam int FLB_SYN = 1;
    localparam int FLB_RST = 2;
    localparam int FLB_PSH = 3;
    localparam int FLB_ACK = 4;

    // connection states
    localparam logic [3:0] ST_CLOSED      = 4'd0;
    localparam logic [3:0] ST_LISTEN      = 4'd1;
    localparam logic [3:0] ST_SYN_RECV    = 4'd3;
    localparam logic [3:0] ST_ESTABLISHED = 4'd4;
    localparam logic [3:0] ST_FIN_WAIT1   = 4'd5;
    localparam logic [3:0] ST_FIN_WAIT2   = 4'd6;
    localparam logic [3:0] ST_TIME_WAIT   = 4'd7;
    localparam logic [3:0] ST_CLOSE_WAIT  = 4'd8;

    // result status codes
    localparam logic [2:0] STS_LISTEN_OK = 3'd0;
    localparam logic [2:0] STS_FULL      = 3'd1;
    localparam logic [2:0] STS_MATCHED   = 3'd2;
    localparam logic [2:0] STS_SEND_RST  = 3'd3;
    localparam logic [2:0] STS_QUIET     = 3'd4;

    typedef struct packed {
        logic        action;
        logic [15:0] port;
        logic [31:0] src_addr;
        logic [15:0] src_port_num;
        logic [5:0]  seg_flags;
        logic [31:0] seg_seq;
        logic [31:0] seg_ack;
        logic [15:0] seg_len;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  slot;
        logic [3:0]  conn_state;
        logic [31:0] ack_out;
        logic [31:0] seq_out;
        logic [15:0] cwnd_out;
    } t_rsp;

    // one connection slot as stored in the table memory
    typedef struct packed {
        logic [15:0] port;
        logic [3:0]  state;
        logic [31:0] peer_addr;
        logic [15:0] peer_port;
        logic [31:0] send_seq;
        logic [31:0] recv_ack;
        logic [15:0] cwnd;
        logic [15:0] ssthresh;
    } t_rec;

    typedef struct packed {
        logic [31:0] init_seq;
        logic [15:0] init_cwnd;
        logic [15:0] init_ssthresh;
    } t_cfg;

    localparam int REC_W = $bits(t_rec);

    // slot index as reported: low six bits
    function automatic logic [5:0] slot_field(input logic [SLOT_W-1:0] idx);
        logic [SLOT_W+5:0] ext;
        ext = {6'd0, idx};
        return ext[5:0];
    endfunction

endpackage
`default_nettype wire

FILE: sv/tcp_ct_ram.sv
`default_nettype none
module tcp_ct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [AW-1:0]        i_waddr,
    input  wire logic [WIDTH-1:0]     i_wdata,
    input  wire logic                 i_re,
    input  wire logic [AW-1:0]        i_raddr,
    output logic      [WIDTH-1:0]     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: sv/tcp_ct_step.sv
`default_nettype none
module tcp_ct_step
    import tcp_ct_pkg::*;
(
    input  wire t_rec i_rec,
    input  wire t_req i_req,
    input  wire t_cfg i_cfg,
    output t_rec      o_rec
);
    logic [31:0] seq_plus1;
    logic [31:0] snd_plus1;
    logic [31:0] ack_plus_len;
    logic [16:0] cwnd_grow;
    logic [15:0] cwnd_sat;

    // shared adders and window growth
    assign seq_plus1    = i_req.seg_seq + 32'd1;
    assign snd_plus1    = i_rec.send_seq + 32'd1;
    assign ack_plus_len = i_rec.recv_ack + {16'd0, i_req.seg_len};
    assign cwnd_grow    = (i_rec.cwnd < i_rec.ssthresh) ? {i_rec.cwnd, 1'b0}
                                                        : ({1'b0, i_rec.cwnd} + 17'd1);
    assign cwnd_sat     = cwnd_grow[16] ? 16'hFFFF : cwnd_grow[15:0];

    // per-slot connection state machine
    always_comb begin
        o_rec = i_rec;
        case (i_rec.state)
            ST_LISTEN: begin
                if (i_req.seg_flags[FLB_SYN]) begin
                    o_rec.state     = ST_SYN_RECV;
                    o_rec.peer_addr = i_req.src_addr;
                    o_rec.peer_port = i_req.src_port_num;
                    o_rec.recv_ack  = seq_plus1;
                    o_rec.send_seq  = i_cfg.init_seq;
                    o_rec.cwnd      = i_cfg.init_cwnd;
                    o_rec.ssthresh  = i_cfg.init_ssthresh;
                end
            end
            ST_SYN_RECV: begin
                if (i_req.seg_flags[FLB_ACK] && (i_req.seg_ack == snd_plus1)) begin
                    o_rec.state    = ST_ESTABLISHED;
                    o_rec.send_seq = snd_plus1;
                end
            end
            ST_ESTABLISHED: begin
                if (i_req.seg_flags[FLB_FIN]) begin
                    o_rec.state    = ST_CLOSE_WAIT;
                    o_rec.recv_ack = seq_plus1;
                end else if (i_req.seg_flags[FLB_PSH] &&
                             (i_req.seg_seq == i_rec.recv_ack)) begin
                    o_rec.recv_ack = ack_plus_len;
                    o_rec.cwnd     = cwnd_sat;
                end
            end
            ST_FIN_WAIT1: begin
                if (i_req.seg_flags[FLB_ACK]) begin
                    o_rec.state = ST_FIN_WAIT2;
                end
            end
            ST_FIN_WAIT2: begin
                if (i_req.seg_flags[FLB_FIN]) begin
                    o_rec.state    = ST_TIME_WAIT;
                    o_rec.recv_ack = seq_plus1;
                end
            end
            default: begin
                o_rec = i_rec;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: sv/tcp_connection_table_fsm.sv
// TCP connection table with a simplified per-slot connection state machine.
// Input channel (i_valid/o_ready, payload i_req): a listen request claims the
// lowest free slot for a port; a segment request is routed to the lowest
// active slot with that port and steps its state. Output channel
// (o_valid/i_ready, payload o_rsp): exactly one result per request.
// Configuration: i_cfg_we/i_cfg_idx/i_cfg_data write the initial sequence
// number, congestion window and slow start threshold, taken at once.
// Slots are claimed in order and never released, so a fill count marks the
// active ones and the slot memory needs no clearing pass.
// Sequence: a listen request writes its slot in S_LST and gives its result
// from S_OUT. A segment scans the port fields of the active slots one per
// cycle through the memory read port: a match goes through S_STEP to S_OUT,
// no match among the active slots goes from S_SCAN to S_OUT, and an empty
// table answers from S_OUT without a scan.
// One request at a time: o_ready is high only while the block is idle, and
// a result held by a stalled receiver keeps the block from taking the next.
// Reset restores the configuration defaults and empties the table.
`default_nettype none
module tcp_connection_table_fsm
    import tcp_ct_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire t_req        i_req,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_rsp             o_rsp,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LST  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_STEP = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [SLOT_W-1:0] r_idx, n_idx;
    logic              r_iss, n_iss;
    logic              r_rd_vld, n_rd_vld;
    logic [SLOT_W-1:0] r_rd_idx, n_rd_idx;
    logic [SLOT_W-1:0] r_slot, n_slot;
    t_rec              r_rec, n_rec;
    t_req              r_req, n_req;
    t_rsp              r_rsp, n_rsp;
    t_cfg              r_cfg;

    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    t_rec              ram_wdata;
    logic              ram_re;
    t_rec              ram_rdata;
    t_rec              step_rec;
    t_rec              listen_rec;
    logic [CNT_W-1:0]  last_idx;
    logic              issue_last;
    logic              rd_last;

    // slot table memory
    tcp_ct_ram #(
        .WIDTH (REC_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    // state machine update for the matched slot
    tcp_ct_step u_step (
        .i_rec (r_rec),
        .i_req (r_req),
        .i_cfg (r_cfg),
        .o_rec (step_rec)
    );

    // fresh slot contents for a listen
    always_comb begin
        listen_rec       = '0;
        listen_rec.port  = r_req.port;
        listen_rec.state = ST_LISTEN;
    end

    assign last_idx   = r_cnt - CNT_W'(1);
    assign issue_last = (CNT_W'(r_idx) == last_idx);
    assign rd_last    = (CNT_W'(r_rd_idx) == last_idx);

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_iss    = r_iss;
        n_rd_vld = 1'b0;
        n_rd_idx = r_rd_idx;
        n_slot   = r_slot;
        n_rec    = r_rec;
        n_req    = r_req;
        n_rsp    = r_rsp;
        ram_we    = 1'b0;
        ram_waddr = r_slot;
        ram_wdata = step_rec;
        ram_re    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_req = i_req;
                    n_idx = '0;
                    n_iss = 1'b1;
                    if (i_req.action == ACT_LISTEN) begin
                        n_state = S_LST;
                    end else if (r_cnt == '0) begin
                        n_rsp        = '0;
                        n_rsp.status = i_req.seg_flags[FLB_RST] ? STS_QUIET : STS_SEND_RST;
                        n_state      = S_OUT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_LST: begin
                n_rsp = '0;
                if (r_cnt == CNT_W'(SLOTS)) begin
                    n_rsp.status = STS_FULL;
                end else begin
                    ram_we           = 1'b1;
                    ram_waddr        = r_cnt[SLOT_W-1:0];
                    ram_wdata        = listen_rec;
                    n_cnt            = r_cnt + CNT_W'(1);
                    n_rsp.status     = STS_LISTEN_OK;
                    n_rsp.slot       = slot_field(r_cnt[SLOT_W-1:0]);
                    n_rsp.conn_state = ST_LISTEN;
                end
                n_state = S_OUT;
            end
            S_SCAN: begin
                if (r_rd_vld && (ram_rdata.port == r_req.port)) begin
                    n_slot  = r_rd_idx;
                    n_rec   = ram_rdata;
                    n_state = S_STEP;
                end else if (r_rd_vld && rd_last) begin
                    n_rsp        = '0;
                    n_rsp.status = r_req.seg_flags[FLB_RST] ? STS_QUIET : STS_SEND_RST;
                    n_state      = S_OUT;
                end else if (r_iss) begin
                    ram_re   = 1'b1;
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_idx;
                    if (issue_last) begin
                        n_iss = 1'b0;
                    end else begin
                        n_idx = r_idx + SLOT_W'(1);
                    end
                end
            end
            S_STEP: begin
                ram_we           = 1'b1;
                ram_waddr        = r_slot;
                ram_wdata        = step_rec;
                n_rsp.status     = STS_MATCHED;
                n_rsp.slot       = slot_field(r_slot);
                n_rsp.conn_state = step_rec.state;
                n_rsp.ack_out    = step_rec.recv_ack;
                n_rsp.seq_out    = step_rec.send_seq;
                n_rsp.cwnd_out   = step_rec.cwnd;
                n_state          = S_OUT;
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_iss    <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_iss    <= n_iss;
            r_rd_vld <= n_rd_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_rd_idx <= n_rd_idx;
        r_slot   <= n_slot;
        r_rec    <= n_rec;
        r_req    <= n_req;
        r_rsp    <= n_rsp;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.init_seq      <= RST_INIT_SEQ;
            r_cfg.init_cwnd     <= RST_INIT_CWND;
            r_cfg.init_ssthresh <= RST_INIT_SSTHRESH;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_INIT_SEQ:      r_cfg.init_seq      <= i_cfg_data;
                CFG_INIT_CWND:     r_cfg.init_cwnd     <= i_cfg_data[15:0];
                CFG_INIT_SSTHRESH: r_cfg.init_ssthresh <= i_cfg_data[15:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_rsp   = r_rsp;

endmodule
`default_nettype wire
